/* rtl/core/lpd_pkg.sv */
// Shared constants and types for the lidar point decoder.
package lpd_pkg;

  // Point cloud geometry.
  localparam int unsigned RING_COUNT          = 126;
  localparam int unsigned POINTS_PER_RING_ROW = 625;
  localparam int unsigned PKTS_PER_RING       = 5;
  localparam int unsigned BLOCKS_PER_PKT      = 25;
  localparam int unsigned PTS_PER_CHAN_ROW    = 125;
  localparam int unsigned NUM_CHAN            = 5;
  localparam int unsigned SEQ_MAX             = RING_COUNT * PKTS_PER_RING;
  localparam int unsigned SEQ_KW              = $clog2(SEQ_MAX);
  localparam int unsigned ROW_W               = $clog2(RING_COUNT);

  // Division by PKTS_PER_RING through a reciprocal multiply.
  localparam int unsigned ROW_SHIFT = 18;
  localparam int unsigned ROW_MUL   = ((1 << ROW_SHIFT) + PKTS_PER_RING - 1) / PKTS_PER_RING;

  // CORDIC settings.
  localparam int unsigned TRIG_STAGES = 16;
  localparam int unsigned XW          = 34;
  localparam int unsigned ZW          = 32;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507, 32'sd23437865,
    32'sd11730358, 32'sd5866610, 32'sd2933484, 32'sd1466764, 32'sd733385,
    32'sd366693, 32'sd183346, 32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
    32'sd5730, 32'sd2865, 32'sd1432, 32'sd716, 32'sd358, 32'sd179, 32'sd90, 32'sd45
  };

  // Range scaling: divide by 25 * 2^30, rounding half away from zero.
  localparam logic [55:0] HALF_DIV = 56'd25 << 29;
  localparam logic [27:0] DIV25_MUL = 28'd171798692;  // ceil(2^32 / 25)

  localparam logic signed [21:0] POS_MAX = 22'sd1048575;
  localparam logic signed [21:0] POS_MIN = -22'sd1048576;
  localparam logic [20:0] MICRO_WRAP = 21'd1000000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_ORIGIN_Z = 2'd2
  } cfg_reg_e;

  // Fields that ride alongside the trig pipeline.
  typedef struct packed {
    logic [15:0] range_raw;
    logic [7:0]  intensity;
    logic [6:0]  ring;
    logic [16:0] cloud_index;
    logic [47:0] seconds;
    logic [19:0] micros;
    logic        in_range;
  } side_t;

endpackage

/* rtl/core/lidar_point_decode.sv */
// Top level of the lidar point decoder: spherical record in, Cartesian point out.
//
// Input stream s_axis carries one channel record per item; output stream
// m_axis carries one decoded point per item, in the same order. An item is
// moved when tvalid and tready are both high.
// The configuration port writes the x, y and z origin offsets (index 0..2,
// 17-bit signed, 1/1024 m); other indexes are ignored. Write it while idle.
// One stage folds the angles and decodes sequence and time, then there is
// one CORDIC stage per iteration, then 34x34 product, range scale, rounding
// and origin/saturation stages. Throughput is one item per cycle while the
// output is not held. The whole pipeline advances together: when the output
// holds an item the receiver has not taken, every stage holds and
// s_axis_tready drops, so nothing is lost or repeated. Reset clears all
// valid bits and zeroes the origin registers; no clearing pass is needed.
module lidar_point_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // packet_seq[15:0], channel_index[18:16], block_index[23:19],
  // time_offset_us[31:24], range_raw[47:32], elevation_raw[63:48],
  // azimuth_raw[79:64], echo_intensity[87:80], packet_seconds[135:88],
  // packet_micros[155:136], zero fill[159:156]
  input  logic [159:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x[20:0], pos_y[41:21], pos_z[62:42], point_intensity[70:63],
  // ring_number[77:71], cloud_index[94:78], point_seconds[142:95],
  // point_micros[162:143], in_range[163], zero fill[167:164]
  output logic [167:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [16:0]   cfg_data_i
);

  localparam int unsigned N = lpd_pkg::TRIG_STAGES;

  // Configuration registers.
  logic signed [16:0] origin_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpd_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        lpd_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        lpd_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the output is held.
  logic adv;
  logic out_vld_q;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Input field unpacking.
  logic [15:0] in_seq, in_rng, in_el, in_az;
  logic [2:0]  in_ch;
  logic [4:0]  in_blk;
  logic [7:0]  in_toff, in_int;
  logic [47:0] in_secs;
  logic [19:0] in_us;
  assign in_seq  = s_axis_tdata[15:0];
  assign in_ch   = s_axis_tdata[18:16];
  assign in_blk  = s_axis_tdata[23:19];
  assign in_toff = s_axis_tdata[31:24];
  assign in_rng  = s_axis_tdata[47:32];
  assign in_el   = s_axis_tdata[63:48];
  assign in_az   = s_axis_tdata[79:64];
  assign in_int  = s_axis_tdata[87:80];
  assign in_secs = s_axis_tdata[135:88];
  assign in_us   = s_axis_tdata[155:136];

  // Angle fold into [-90, 90] degrees, recording a half-turn.
  logic signed [lpd_pkg::ZW-1:0] el_z, az_z;
  logic el_neg, az_neg;

  always_comb begin
    logic signed [16:0] a;
    a = $signed({1'b0, in_el}) - 17'sd32768;
    if (a > 17'sd18000) a = a - 17'sd36000;
    if (a < -17'sd18000) a = a + 17'sd36000;
    el_neg = 1'b0;
    if (a > 17'sd9000) begin
      a = a - 17'sd18000;
      el_neg = 1'b1;
    end else if (a < -17'sd9000) begin
      a = a + 17'sd18000;
      el_neg = 1'b1;
    end
    el_z = {a[15:0], 16'd0};
  end

  always_comb begin
    logic signed [16:0] a;
    a = $signed({1'b0, in_az}) - 17'sd32768;
    if (a > 17'sd18000) a = a - 17'sd36000;
    if (a < -17'sd18000) a = a + 17'sd36000;
    az_neg = 1'b0;
    if (a > 17'sd9000) begin
      a = a - 17'sd18000;
      az_neg = 1'b1;
    end else if (a < -17'sd9000) begin
      a = a + 17'sd18000;
      az_neg = 1'b1;
    end
    az_z = {a[15:0], 16'd0};
  end

  // Ring, cloud slot and point time from the header fields.
  lpd_pkg::side_t side_d;

  always_comb begin
    logic [lpd_pkg::SEQ_KW-1:0] k;
    logic [lpd_pkg::SEQ_KW+lpd_pkg::ROW_SHIFT-1:0] kp;
    logic [lpd_pkg::ROW_W-1:0] row;
    logic [2:0] msg;
    logic [31:0] slot;
    logic [20:0] us;
    logic ok;
    ok   = (in_seq >= 16'd1) && (32'(in_seq) <= lpd_pkg::SEQ_MAX) &&
           (32'(in_ch) < lpd_pkg::NUM_CHAN) && (32'(in_blk) < lpd_pkg::BLOCKS_PER_PKT);
    k    = lpd_pkg::SEQ_KW'(in_seq - 16'd1);
    kp   = (lpd_pkg::SEQ_KW+lpd_pkg::ROW_SHIFT)'(k) *
           (lpd_pkg::SEQ_KW+lpd_pkg::ROW_SHIFT)'(lpd_pkg::ROW_MUL);
    row  = lpd_pkg::ROW_W'(kp >> lpd_pkg::ROW_SHIFT);
    msg  = 3'(32'(k) - 32'(row) * lpd_pkg::PKTS_PER_RING);
    slot = 32'(in_blk) + 32'(msg) * lpd_pkg::BLOCKS_PER_PKT +
           32'(in_ch) * lpd_pkg::PTS_PER_CHAN_ROW + 32'(row) * lpd_pkg::POINTS_PER_RING_ROW;
    side_d.range_raw   = in_rng;
    side_d.intensity   = in_int;
    side_d.in_range    = ok;
    side_d.ring        = ok ? 7'(32'(lpd_pkg::RING_COUNT - 1) - 32'(row)) : 7'd0;
    side_d.cloud_index = ok ? slot[16:0] : 17'd0;
    us = {1'b0, in_us} + 21'(in_toff);
    if (us >= lpd_pkg::MICRO_WRAP) begin
      side_d.micros  = 20'(us - lpd_pkg::MICRO_WRAP);
      side_d.seconds = in_secs + 48'd1;
    end else begin
      side_d.micros  = us[19:0];
      side_d.seconds = in_secs;
    end
  end

  // Stage 0: folded angles and decoded side fields.
  logic                          vld_q [N+1];
  lpd_pkg::side_t                side_q [N+1];
  logic signed [lpd_pkg::ZW-1:0] el_z_q, az_z_q;
  logic                          el_neg_q, az_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      el_z_q    <= el_z;
      az_z_q    <= az_z;
      el_neg_q  <= el_neg;
      az_neg_q  <= az_neg;
    end
  end

  // Valid bits and side fields follow the CORDIC stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= N; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i <= N; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Sine and cosine of elevation and azimuth.
  logic signed [lpd_pkg::XW-1:0] cos_el, sin_el, cos_az, sin_az;

  lpd_cordic u_cordic_el (
    .clk_i (clk_i),
    .en_i  (adv),
    .z_i   (el_z_q),
    .neg_i (el_neg_q),
    .cos_o (cos_el),
    .sin_o (sin_el)
  );

  lpd_cordic u_cordic_az (
    .clk_i (clk_i),
    .en_i  (adv),
    .z_i   (az_z_q),
    .neg_i (az_neg_q),
    .cos_o (cos_az),
    .sin_o (sin_az)
  );

  // Product stage: cos_el times cos_az and sin_az.
  logic                          m1_vld_q;
  lpd_pkg::side_t                m1_side_q;
  logic signed [2*lpd_pkg::XW-1:0] prod_x_q, prod_y_q;
  logic signed [lpd_pkg::XW-1:0] sin_el_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_x_q  <= cos_el * cos_az;
      prod_y_q  <= cos_el * sin_az;
      sin_el_q  <= sin_el;
      m1_side_q <= side_q[N];
    end
  end

  // Range scale stage: t = range * 128 * factor.
  logic                 m2_vld_q;
  lpd_pkg::side_t       m2_side_q;
  logic signed [55:0]   t_q [3];
  logic signed [lpd_pkg::XW-1:0] fac [3];
  logic signed [23:0]   rng_s;

  assign fac[0] = lpd_pkg::XW'(prod_x_q >>> 30);
  assign fac[1] = lpd_pkg::XW'(prod_y_q >>> 30);
  assign fac[2] = sin_el_q;
  assign rng_s  = $signed({1'b0, m1_side_q.range_raw, 7'd0});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) t_q[a] <= 56'(rng_s) * 56'(fac[a]);
      m2_side_q <= m1_side_q;
    end
  end

  // Rounding stage: magnitude plus half divisor, then drop 30 bits.
  logic                 m3_vld_q;
  lpd_pkg::side_t       m3_side_q;
  logic [25:0]          v_q [3];
  logic                 sgn_q [3];

  always_ff @(posedge clk_i) begin
    logic [55:0] mag;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        mag      = t_q[a][55] ? 56'(-t_q[a]) : 56'(t_q[a]);
        v_q[a]   <= 26'((mag + lpd_pkg::HALF_DIV) >> 30);
        sgn_q[a] <= t_q[a][55];
      end
      m3_side_q <= m2_side_q;
    end
  end

  // Output stage: divide by 25, restore sign, add origin and saturate.
  lpd_pkg::side_t out_side_q;
  logic [20:0]    pos_q [3];

  always_ff @(posedge clk_i) begin
    logic [53:0] qp;
    logic signed [21:0] q, s;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        qp = 54'(v_q[a]) * 54'(lpd_pkg::DIV25_MUL);
        q  = $signed({1'b0, 21'(qp >> 32)});
        if (sgn_q[a]) q = -q;
        s  = q + 22'(origin_q[a]);
        if (s > lpd_pkg::POS_MAX) s = lpd_pkg::POS_MAX;
        if (s < lpd_pkg::POS_MIN) s = lpd_pkg::POS_MIN;
        pos_q[a] <= s[20:0];
      end
      out_side_q <= m3_side_q;
    end
  end

  // Valid bits of the back-end stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      m3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q  <= vld_q[N];
      m2_vld_q  <= m1_vld_q;
      m3_vld_q  <= m2_vld_q;
      out_vld_q <= m3_vld_q;
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_side_q.in_range, out_side_q.micros, out_side_q.seconds,
                          out_side_q.cloud_index, out_side_q.ring, out_side_q.intensity,
                          pos_q[2], pos_q[1], pos_q[0]};

endmodule

/* rtl/core/lpd_cordic.sv */
// Pipelined rotation-mode CORDIC giving cosine and sine in Q30.
module lpd_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lpd_pkg::ZW-1:0]     z_i,
  input  logic                              neg_i,
  output logic signed [lpd_pkg::XW-1:0]     cos_o,
  output logic signed [lpd_pkg::XW-1:0]     sin_o
);

  localparam int unsigned N = lpd_pkg::TRIG_STAGES;

  logic signed [lpd_pkg::XW-1:0] x_in [N];
  logic signed [lpd_pkg::XW-1:0] y_in [N];
  logic signed [lpd_pkg::ZW-1:0] z_in [N];
  logic                          n_in [N];
  logic signed [lpd_pkg::XW-1:0] x_q  [N];
  logic signed [lpd_pkg::XW-1:0] y_q  [N];
  logic signed [lpd_pkg::ZW-1:0] z_q  [N];
  logic                          n_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    // Each stage takes the previous stage's registers, the first takes the input.
    if (i == 0) begin : g_first
      assign x_in[i] = lpd_pkg::CORDIC_GAIN;
      assign y_in[i] = '0;
      assign z_in[i] = z_i;
      assign n_in[i] = neg_i;
    end else begin : g_next
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
      assign n_in[i] = n_q[i-1];
    end

    // One micro-rotation per stage.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_in[i] >= 0) begin
          x_q[i] <= x_in[i] - (y_in[i] >>> i);
          y_q[i] <= y_in[i] + (x_in[i] >>> i);
          z_q[i] <= z_in[i] - lpd_pkg::ATAN_TAB[i];
        end else begin
          x_q[i] <= x_in[i] + (y_in[i] >>> i);
          y_q[i] <= y_in[i] - (x_in[i] >>> i);
          z_q[i] <= z_in[i] + lpd_pkg::ATAN_TAB[i];
        end
        n_q[i] <= n_in[i];
      end
    end
  end

  // Undo the half-turn fold.
  assign cos_o = n_q[N-1] ? -x_q[N-1] : x_q[N-1];
  assign sin_o = n_q[N-1] ? -y_q[N-1] : y_q[N-1];

endmodule

/* rtl/core/lpd_checker.sv */
// Port-level checks for the lidar point decoder, bound to the top level.
module lpd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata
);

  // A held output stalls the whole pipeline, so the input must back off.
  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output is stalled");

  // A stalled output item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  // Points outside the sequence, channel or block window carry no ring and no slot.
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[163] |-> m_axis_tdata[94:71] == 24'd0)
    else $error("ring or slot set for an out-of-range point");

  // Ring and slot stay inside the cloud for valid points.
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[163] |->
      m_axis_tdata[77:71] <= 7'd125 && m_axis_tdata[94:78] <= 17'd78749)
    else $error("ring or slot beyond the cloud");

  // The microsecond part is always normalized.
  a_micros: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[162:143] < 20'd1000000)
    else $error("point microseconds not normalized");

endmodule

bind lidar_point_decode lpd_checker u_lpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/lidar_point_decode_tb.sv */
// Testbench for the lidar point decoder: directed and random records checked against a point predictor.
`timescale 1ns / 1ps

module lidar_point_decode_tb;

  // One decoded point as it appears on the output bus.
  typedef struct packed {
    logic [3:0]         pad;
    logic               in_range;
    logic [19:0]        micros;
    logic [47:0]        seconds;
    logic [16:0]        cloud_index;
    logic [6:0]         ring;
    logic [7:0]         intensity;
    logic signed [20:0] pz;
    logic signed [20:0] py;
    logic signed [20:0] px;
  } point_t;

  // One channel record as it appears on the input bus.
  typedef struct packed {
    logic [3:0]  pad;
    logic [19:0] micros;
    logic [47:0] seconds;
    logic [7:0]  intensity;
    logic [15:0] azimuth;
    logic [15:0] elevation;
    logic [15:0] range_raw;
    logic [7:0]  toff;
    logic [4:0]  blk;
    logic [2:0]  chan;
    logic [15:0] seq;
  } record_t;

  localparam longint CYCLE_LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [167:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [16:0]  cfg_data_i = '0;

  point_t       expected_points[$];
  longint       origin[3];
  int           mismatches = 0;
  longint       cycles = 0;

  lidar_point_decode dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lidar_point_decode");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation-mode CORDIC on a raw angle in centidegrees offset by 32768.
  function automatic void cordic_sincos(input logic [15:0] raw, output longint c,
                                        output longint s);
    longint a, x, y, z, nx;
    bit flip;
    a = longint'(raw) - 32768;
    flip = 0;
    if (a > 18000) a -= 36000;
    if (a < -18000) a += 36000;
    if (a > 9000) begin
      a -= 18000;
      flip = 1;
    end else if (a < -9000) begin
      a += 18000;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < lpd_pkg::TRIG_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(lpd_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(lpd_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Range times factor over 25 * 2^30, rounded half away from zero, then origin and clamp.
  function automatic logic [20:0] scaled_position(logic [15:0] r, longint f, longint org);
    longint t, m, q, v;
    t = longint'(r) * 128 * f;
    m = t < 0 ? -t : t;
    q = (m + (longint'(25) << 29)) / (longint'(25) << 30);
    v = (t < 0 ? -q : q) + org;
    if (v > 1048575) v = 1048575;
    if (v < -1048576) v = -1048576;
    return v[20:0];
  endfunction

  function automatic point_t decode_point(record_t rec);
    point_t p;
    longint ce, se, ca, sa, row, msg, us;
    cordic_sincos(rec.elevation, ce, se);
    cordic_sincos(rec.azimuth, ca, sa);
    p = '0;
    p.px = scaled_position(rec.range_raw, floor_shift(ce * ca, 30), origin[0]);
    p.py = scaled_position(rec.range_raw, floor_shift(ce * sa, 30), origin[1]);
    p.pz = scaled_position(rec.range_raw, se, origin[2]);
    p.intensity = rec.intensity;
    if (rec.seq >= 1 && rec.seq <= lpd_pkg::SEQ_MAX && rec.chan < lpd_pkg::NUM_CHAN &&
        rec.blk < lpd_pkg::BLOCKS_PER_PKT) begin
      row = (longint'(rec.seq) - 1) / lpd_pkg::PKTS_PER_RING;
      msg = (longint'(rec.seq) - 1) % lpd_pkg::PKTS_PER_RING;
      p.in_range = 1'b1;
      p.ring = 7'(longint'(lpd_pkg::RING_COUNT) - 1 - row);
      p.cloud_index = 17'(longint'(rec.blk) + msg * lpd_pkg::BLOCKS_PER_PKT +
                          longint'(rec.chan) * lpd_pkg::PTS_PER_CHAN_ROW +
                          row * lpd_pkg::POINTS_PER_RING_ROW);
    end
    us = longint'(rec.micros) + longint'(rec.toff);
    p.seconds = rec.seconds;
    if (us >= 1000000) begin
      us -= 1000000;
      p.seconds = rec.seconds + 48'd1;
    end
    p.micros = us[19:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // Output side: comparison against the oldest prediction, then a random hold-off.
  initial begin
    point_t got, want;
    int gap;
    forever begin
      @(posedge clk_i);
      if (m_axis_tready && m_axis_tvalid) begin
        got = m_axis_tdata;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected point", 0, 0);
        end else begin
          want = expected_points.pop_front();
          if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
          if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
          if (got.pz != want.pz) report_mismatch("pos_z", got.pz, want.pz);
          if (got.intensity != want.intensity)
            report_mismatch("intensity", got.intensity, want.intensity);
          if (got.ring != want.ring) report_mismatch("ring", got.ring, want.ring);
          if (got.cloud_index != want.cloud_index)
            report_mismatch("cloud_index", got.cloud_index, want.cloud_index);
          if (got.seconds != want.seconds)
            report_mismatch("seconds", got.seconds, want.seconds);
          if (got.micros != want.micros) report_mismatch("micros", got.micros, want.micros);
          if (got.in_range != want.in_range)
            report_mismatch("in_range", got.in_range, want.in_range);
        end
        // Quiet stretches with no stalls, otherwise a random hold-off.
        gap = ((cycles / 2000) % 4 == 1) ? 0 : int'($urandom_range(0, 11));
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Send one record, after a random gap, and record its prediction on acceptance.
  task automatic send_record(record_t rec);
    int gap;
    gap = ((cycles / 2000) % 4 == 2) ? 0 : int'($urandom_range(0, 11));
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rec;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_points.push_back(decode_point(rec));
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (lpd_pkg::TRIG_STAGES + 10) @(posedge clk_i);
  endtask

  // One register write, after which the task waits with the write enable low.
  task automatic write_origin(lpd_pkg::cfg_reg_e idx, logic [16:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    origin[idx] = longint'(signed'(value));
    @(posedge clk_i);
  endtask

  function automatic record_t random_record();
    record_t rec;
    rec = {$urandom, $urandom, $urandom, $urandom, $urandom};
    rec.pad = '0;
    return rec;
  endfunction

  // Well-formed records with in-range positions in the cloud.
  function automatic record_t plausible_record();
    record_t rec;
    rec = random_record();
    rec.seq = 16'($urandom_range(1, lpd_pkg::SEQ_MAX));
    rec.chan = 3'($urandom_range(0, lpd_pkg::NUM_CHAN - 1));
    rec.blk = 5'($urandom_range(0, lpd_pkg::BLOCKS_PER_PKT - 1));
    rec.micros = 20'($urandom_range(0, 999999));
    case ($urandom_range(0, 3))
      0: rec.range_raw = 16'($urandom_range(0, 4000));
      1: rec.elevation = 16'(32768 + $urandom_range(0, 6000) - 3000);
      default: ;
    endcase
    return rec;
  endfunction

  // Field extremes, sequence/channel/block limits and microsecond carry.
  task automatic test_directed();
    record_t rec;
    logic [15:0] angles[8] = '{16'd0, 16'd65535, 16'd32768, 16'd41768, 16'd23768,
                                 16'd50768, 16'd14768, 16'd32769};
    for (int i = 0; i < 8; i++) begin
      rec = '0;
      rec.seq = (i == 0) ? 16'd0 : (i == 1) ? 16'd1 : (i == 2) ? 16'(lpd_pkg::SEQ_MAX) :
                (i == 3) ? 16'(lpd_pkg::SEQ_MAX + 1) : (i == 4) ? 16'hFFFF : 16'd6;
      rec.chan = (i == 5) ? 3'd7 : (i == 6) ? 3'd5 : 3'd4;
      rec.blk = (i == 7) ? 5'd25 : (i == 6) ? 5'd31 : 5'd24;
      rec.range_raw = (i % 2) ? 16'hFFFF : 16'd1000;
      rec.elevation = angles[i];
      rec.azimuth = angles[7 - i];
      rec.intensity = 8'(i * 37);
      rec.toff = (i < 4) ? 8'hFF : 8'd0;
      rec.micros = (i == 0) ? 20'd999999 : (i == 1) ? 20'hFFFFF : (i == 2) ? 20'd999744 :
                   20'(i);
      rec.seconds = (i < 2) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom});
      send_record(rec);
    end
    rec = '0;
    send_record(rec);
    rec = '1;
    rec.pad = '0;
    send_record(rec);
    drain_pipeline();
  endtask

  // Random records under one origin setting.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_record(($urandom_range(0, 4) == 0) ? random_record() : plausible_record());
    drain_pipeline();
  endtask

  initial begin
    origin = '{0, 0, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(258);
    // Origins at the 17-bit signed extremes offset every position.
    write_origin(lpd_pkg::REG_ORIGIN_X, 17'h0FFFF);
    write_origin(lpd_pkg::REG_ORIGIN_Y, 17'h10000);
    write_origin(lpd_pkg::REG_ORIGIN_Z, 17'h0FFFF);
    test_directed();
    test_random(258);
    write_origin(lpd_pkg::REG_ORIGIN_X, 17'h10000);
    write_origin(lpd_pkg::REG_ORIGIN_Y, 17'h0FFFF);
    write_origin(lpd_pkg::REG_ORIGIN_Z, 17'h10000);
    test_random(258);
    write_origin(lpd_pkg::REG_ORIGIN_X, 17'($urandom));
    write_origin(lpd_pkg::REG_ORIGIN_Y, 17'($urandom));
    write_origin(lpd_pkg::REG_ORIGIN_Z, 17'($urandom));
    test_random(258);
    if (mismatches == 0) begin
      $display("PASS lidar_point_decode");
    end else begin
      $display("FAIL lidar_point_decode");
    end
    $finish;
  end

endmodule
